// ----- sv/smc_pkg.sv -----
package smc_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int WINDOW_RESET    = 3;
    localparam int COST_BITS_DEF   = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF);

    // control broadcast from the sequencer to every cell of the sorted row
    typedef struct packed {
        logic insert;
        logic load_dev;
        logic full;
    } smc_cell_ctl_t;

endpackage

// ----- sv/smc_sample_if.sv -----
interface smc_sample_if import smc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/smc_cost_if.sv -----
interface smc_cost_if import smc_pkg::*; #(
    parameter int COST_BITS = COST_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [COST_BITS-1:0] cost;

    modport source (output valid, output cost, input ready);
    modport sink (input valid, input cost, output ready);
endinterface

// ----- sv/smc_cell.sv -----
module smc_cell import smc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int AGE_W       = 6,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                          clk,
    input  smc_cell_ctl_t                 ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [CNT_W-1:0]       count,
    input  logic        [CNT_W-1:0]       w_eff,
    input  logic        [CNT_W-1:0]       r_pos,
    input  logic        [AGE_W-1:0]       win_last,
    input  logic signed [SAMPLE_BITS-1:0] med,
    input  logic signed [SAMPLE_BITS-1:0] left_value,
    input  logic        [AGE_W-1:0]       left_age,
    input  logic                          left_a,
    input  logic signed [SAMPLE_BITS-1:0] right_value,
    input  logic        [AGE_W-1:0]       right_age,
    input  logic                          right_le,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic        [AGE_W-1:0]       age,
    output logic                          le,
    output logic                          rm,
    output logic                          a,
    output logic        [SAMPLE_BITS-1:0] dev
);

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic        [AGE_W-1:0]       age_reg;
    logic        [AGE_W-1:0]       age_next;
    logic        [SAMPLE_BITS-1:0] dev_reg;
    logic        [SAMPLE_BITS-1:0] dev_next;
    logic                          valid;
    logic                          in_win;
    logic                          before_r;
    logic                          upto_r;
    logic signed [SAMPLE_BITS:0]   diff;

    assign valid    = CNT_W'(INDEX) < count;
    assign in_win   = CNT_W'(INDEX) < w_eff;
    assign before_r = CNT_W'(INDEX) < r_pos;
    assign upto_r   = CNT_W'(INDEX) <= r_pos;

    assign le = valid && (value_reg <= sample);
    assign rm = valid && ctl.full && (age_reg == win_last);
    // the element that lands here after removal is below or equal to the new sample
    assign a  = before_r ? le : right_le;

    always_comb
    begin
        if (a)
        begin
            value_next = before_r ? value_reg : right_value;
            age_next   = (before_r ? age_reg : right_age) + AGE_W'(1);
        end
        else if (left_a)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else
        begin
            value_next = upto_r ? left_value : value_reg;
            age_next   = (upto_r ? left_age : age_reg) + AGE_W'(1);
        end
    end

    assign diff     = {value_reg[SAMPLE_BITS-1], value_reg} - {med[SAMPLE_BITS-1], med};
    assign dev_next = in_win ? SAMPLE_BITS'(diff[SAMPLE_BITS] ? -diff : diff) : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.insert)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
        if (ctl.load_dev)
        begin
            dev_reg <= dev_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;
    assign dev   = dev_reg;

endmodule

// ----- sv/smc_sum_tree.sv -----
module smc_sum_tree #(
    parameter int LEAVES = 64,
    parameter int IN_W   = 32,
    parameter int OUT_W  = 38
) (
    input  logic             clk,
    input  logic [IN_W-1:0]  leaf [LEAVES],
    output logic [OUT_W-1:0] root
);

    localparam int LVL = $clog2(LEAVES);
    localparam int N2  = 1 << LVL;

    logic [OUT_W-1:0] leaf_w [N2];

    genvar j;
    genvar i;

    generate
        for (j = 0; j < N2; j++)
        begin : g_leaf
            if (j < LEAVES)
            begin : g_used
                assign leaf_w[j] = OUT_W'(leaf[j]);
            end
            else
            begin : g_pad
                assign leaf_w[j] = '0;
            end
        end

        if (LVL == 0)
        begin : g_single
            assign root = leaf_w[0];
        end
        else
        begin : g_tree
            // heap order: node i adds nodes 2i+1 and 2i+2, one register level each
            logic [OUT_W-1:0] node_reg [N2-1];
            for (i = 0; i < N2 - 1; i++)
            begin : g_node
                logic [OUT_W-1:0] lhs;
                logic [OUT_W-1:0] rhs;
                if (2 * i + 1 >= N2 - 1)
                begin : g_from_leaf
                    assign lhs = leaf_w[2 * i + 1 - (N2 - 1)];
                    assign rhs = leaf_w[2 * i + 2 - (N2 - 1)];
                end
                else
                begin : g_from_node
                    assign lhs = node_reg[2 * i + 1];
                    assign rhs = node_reg[2 * i + 2];
                end
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= lhs + rhs;
                end
            end
            assign root = node_reg[0];
        end
    endgenerate

endmodule

// ----- sv/sliding_window_median_cost_top.sv -----
// each sample is registered and inserted into the sorted cell row; once the window is full, the
// deviations from the median are loaded and summed through the registered adder tree into the
//   output register; a sample after which the window is not yet full gives no result
// one sample at a time; the output register holds a result while the next sample enters
// reset: asynchronous, active low; window size 3, window empty, no result pending
module sliding_window_median_cost_top import smc_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    smc_sample_if.sink          sample_ch,
    smc_cost_if.source          cost_ch,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    localparam int LVL       = $clog2(MAX_WINDOW);
    localparam int IDX_W     = (LVL > 0) ? LVL : 1;
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int SUMC_W    = ($clog2(LVL + 1) > 0) ? $clog2(LVL + 1) : 1;
    localparam int COST_BITS = SAMPLE_BITS + LVL;
    localparam int W_RST     = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_MED   = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [CNT_W-1:0]              w_eff_reg;
    logic [CNT_W-1:0]              w_eff_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [SUMC_W-1:0]             sum_cnt_reg;
    logic [SUMC_W-1:0]             sum_cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [COST_BITS-1:0]          cost_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic [CNT_W-1:0]              cfg_w;
    logic                          full;
    logic                          in_xact;
    logic                          out_load;
    logic [CNT_W-1:0]              w_m1;
    logic [IDX_W-1:0]              win_last;
    logic [IDX_W-1:0]              med_idx;
    logic signed [SAMPLE_BITS-1:0] med;
    logic [CNT_W-1:0]              enc;
    logic [CNT_W-1:0]              r_pos;
    logic [COST_BITS-1:0]          cost_sum;
    smc_cell_ctl_t                 ctl;

    logic signed [SAMPLE_BITS-1:0] value_w [MAX_WINDOW];
    logic        [IDX_W-1:0]       age_w   [MAX_WINDOW];
    logic        [SAMPLE_BITS-1:0] dev_w   [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  le_w;
    logic        [MAX_WINDOW-1:0]  rm_w;
    logic        [MAX_WINDOW-1:0]  a_w;

    assign full     = count_reg == w_eff_reg;
    assign in_xact  = sample_ch.valid && sample_ch.ready;
    assign w_m1     = w_eff_reg - CNT_W'(1);
    assign win_last = IDX_W'(w_m1);
    assign med_idx  = IDX_W'(w_m1 >> 1);
    assign med      = value_w[med_idx];

    assign ctl.insert   = state_reg == ST_SHIFT;
    assign ctl.load_dev = state_reg == ST_MED;
    assign ctl.full     = full;

    // window size zero acts as one, anything above the built depth saturates
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_w = CNT_W'(1);
        end
        else if (int'(cfg_wdata) > MAX_WINDOW)
        begin
            cfg_w = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_w = CNT_W'(cfg_wdata);
        end
    end

    // position of the leaving sample; past the end when the window is still filling
    always_comb
    begin
        enc = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            if (rm_w[k])
            begin
                enc = enc | CNT_W'(k);
            end
        end
        r_pos = (|rm_w) ? enc : CNT_W'(MAX_WINDOW);
    end

    genvar j;
    generate
        for (j = 0; j < MAX_WINDOW; j++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] left_value;
            logic        [IDX_W-1:0]       left_age;
            logic                          left_a;
            logic signed [SAMPLE_BITS-1:0] right_value;
            logic        [IDX_W-1:0]       right_age;
            logic                          right_le;

            if (j == 0)
            begin : g_first
                assign left_value = sample_reg;
                assign left_age   = '0;
                assign left_a     = 1'b1;
            end
            else
            begin : g_mid
                assign left_value = value_w[j-1];
                assign left_age   = age_w[j-1];
                assign left_a     = a_w[j-1];
            end

            if (j == MAX_WINDOW - 1)
            begin : g_last
                assign right_value = sample_reg;
                assign right_age   = '0;
                assign right_le    = 1'b0;
            end
            else
            begin : g_inner
                assign right_value = value_w[j+1];
                assign right_age   = age_w[j+1];
                assign right_le    = le_w[j+1];
            end

            smc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_W       (IDX_W),
                .CNT_W       (CNT_W),
                .INDEX       (j)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .sample      (sample_reg),
                .count       (count_reg),
                .w_eff       (w_eff_reg),
                .r_pos       (r_pos),
                .win_last    (win_last),
                .med         (med),
                .left_value  (left_value),
                .left_age    (left_age),
                .left_a      (left_a),
                .right_value (right_value),
                .right_age   (right_age),
                .right_le    (right_le),
                .value       (value_w[j]),
                .age         (age_w[j]),
                .le          (le_w[j]),
                .rm          (rm_w[j]),
                .a           (a_w[j]),
                .dev         (dev_w[j])
            );
        end
    endgenerate

    smc_sum_tree #(
        .LEAVES (MAX_WINDOW),
        .IN_W   (SAMPLE_BITS),
        .OUT_W  (COST_BITS)
    ) u_sum_tree (
        .clk  (clk),
        .leaf (dev_w),
        .root (cost_sum)
    );

    assign out_load = (state_reg == ST_SUM) && (sum_cnt_reg == '0)
                      && (!out_valid_reg || cost_ch.ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_cnt_next   = sum_cnt_reg;
        w_eff_next     = w_eff_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && cost_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (full || (count_reg + CNT_W'(1) == w_eff_reg))
                begin
                    state_next = ST_MED;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MED:
            begin
                sum_cnt_next = SUMC_W'(LVL);
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                if (sum_cnt_reg != '0)
                begin
                    sum_cnt_next = sum_cnt_reg - SUMC_W'(1);
                end
                else if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new window size restarts the window empty
        if (cfg_we)
        begin
            w_eff_next = cfg_w;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            w_eff_reg     <= CNT_W'(W_RST);
            count_reg     <= '0;
            sum_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_eff_reg     <= w_eff_next;
            count_reg     <= count_next;
            sum_cnt_reg   <= sum_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            sample_reg <= sample_ch.sample;
        end
        if (out_load)
        begin
            cost_reg <= cost_sum;
        end
    end

    assign sample_ch.ready = state_reg == ST_IDLE;
    assign cost_ch.valid   = out_valid_reg;
    assign cost_ch.cost    = cost_reg;

endmodule
